// ===== hw/rtl/sqrob_pkg.sv =====
`timescale 1ns / 1ps
// Shared constants, types and helpers of the sequence reorder buffer.
package sqrob_pkg;

    localparam int unsigned WINDOW      = 16;
    localparam int unsigned SLOT_W      = $clog2(WINDOW);
    localparam int unsigned MAX_RESULTS = 16;
    localparam int unsigned CNT_W       = $clog2(MAX_RESULTS + 1);
    localparam int unsigned ID_W        = 32;
    localparam int unsigned DESC_W      = 32;

    localparam logic [1:0] STATUS_RELEASED = 2'd0;
    localparam logic [1:0] STATUS_STALE    = 2'd1;
    localparam logic [1:0] STATUS_BEYOND   = 2'd2;

    localparam logic ALU_SUB = 1'b0;
    localparam logic ALU_INC = 1'b1;

    typedef logic [ID_W-1:0]   id_t;
    typedef logic [SLOT_W-1:0] slot_t;

    typedef struct packed {
        id_t  result;
        logic stale;
        logic beyond;
    } alu_res_t;

    typedef struct packed {
        logic              ok;
        logic [DESC_W-1:0] desc;
    } entry_t;

    typedef struct packed {
        logic   wr_en;
        slot_t  wr_slot;
        entry_t wr_data;
        logic   rd_en;
        slot_t  rd_slot;
        logic   clr_all;
    } store_cmd_t;

    // WINDOW is a power of two, so this reduces to the low id bits
    function automatic slot_t slot_of(input id_t id);
        return SLOT_W'(id % WINDOW);
    endfunction

endpackage

// ===== hw/rtl/sqrob_channels.sv =====
`timescale 1ns / 1ps
// Handshake channel interfaces: completion input, result output, config write.
interface sqrob_in_if;
    logic        valid;
    logic        ready;
    logic [31:0] seq_id;
    logic        ok_flag;
    logic [31:0] descriptor;

    modport source (output valid, seq_id, ok_flag, descriptor, input ready);
    modport sink   (input valid, seq_id, ok_flag, descriptor, output ready);
endinterface

interface sqrob_out_if;
    logic        valid;
    logic        ready;
    logic [1:0]  status;
    logic [31:0] out_seq_id;
    logic        out_ok;
    logic [31:0] out_descriptor;
    logic        last;

    modport source (output valid, status, out_seq_id, out_ok, out_descriptor, last,
                    input ready);
    modport sink   (input valid, status, out_seq_id, out_ok, out_descriptor, last,
                    output ready);
endinterface

interface sqrob_cfg_if;
    logic        valid;
    logic        ready;
    logic [31:0] first_expected_id;

    modport source (output valid, first_expected_id, input ready);
    modport sink   (input valid, first_expected_id, output ready);
endinterface

// ===== hw/rtl/sqrob_alu.sv =====
`timescale 1ns / 1ps
// Shared 32-bit adder: window offset with classification, or pointer increment.
module sqrob_alu (
    input  logic                op,
    input  sqrob_pkg::id_t      a,
    input  sqrob_pkg::id_t      b,
    output sqrob_pkg::alu_res_t res
);
    import sqrob_pkg::*;

    id_t  operand_b;
    logic carry_in;
    id_t  sum;

    always_comb
    begin
        // subtract as a + ~b + 1
        operand_b = (op == ALU_INC) ? ID_W'(1) : ~b;
        carry_in  = (op == ALU_SUB);
        sum       = a + operand_b + ID_W'(carry_in);

        res.result = sum;
        res.stale  = sum[ID_W-1];
        res.beyond = !sum[ID_W-1] && (sum[ID_W-2:0] >= (ID_W-1)'(WINDOW));
    end

endmodule

// ===== hw/rtl/sqrob_slot_store.sv =====
`timescale 1ns / 1ps
// Ring slot storage: valid flags in flops, entries in a registered-read memory.
module sqrob_slot_store (
    input  logic                  clk,
    input  logic                  rst_n,
    input  sqrob_pkg::store_cmd_t cmd,
    input  sqrob_pkg::slot_t      probe_slot,
    output logic                  probe_valid,
    output sqrob_pkg::entry_t     rd_data
);
    import sqrob_pkg::*;

    logic [WINDOW-1:0] valid_reg;
    logic [WINDOW-1:0] valid_next;
    entry_t            slot_mem_reg [WINDOW];
    entry_t            rd_data_reg;

    always_comb
    begin
        valid_next = valid_reg;
        if (cmd.clr_all)
        begin
            valid_next = '0;
        end
        else
        begin
            // release clears, insert sets
            if (cmd.rd_en)
            begin
                valid_next[cmd.rd_slot] = 1'b0;
            end
            if (cmd.wr_en)
            begin
                valid_next[cmd.wr_slot] = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= '0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (cmd.wr_en)
        begin
            slot_mem_reg[cmd.wr_slot] <= cmd.wr_data;
        end
        if (cmd.rd_en)
        begin
            rd_data_reg <= slot_mem_reg[cmd.rd_slot];
        end
    end

    assign probe_valid = valid_reg[probe_slot];
    assign rd_data     = rd_data_reg;

endmodule

// ===== hw/rtl/sequence_reorder_buffer_unit.sv =====
`timescale 1ns / 1ps
// Top level of the sequence reorder buffer with in-order release.
//
// Completions enter on req (seq_id, ok_flag, descriptor) in any order. An id
// inside [expected, expected + 16) is stored in ring slot seq_id mod 16; after
// each insert the unit releases, on rsp, every consecutive stored entry from
// the expected id onward (at most 16 per insert) and raises last on the final
// one. Stale ids and ids at or past the window end are not stored: they come
// back at once as one result with status stale or beyond window, last set.
// An insert that leaves the expected slot empty produces no result.
// cfg loads the expected id and clears all slots; write it only while idle.
// One adder serves both the window offset and the pointer increment, and the
// slot memory has one registered read port: an insert passes classify and
// check, each released entry adds a load and a check, and req is ready only
// between inserts. Released entries pass the read and hold registers to rsp.
// Reset empties all slots, sets the expected id to 1 and drops rsp.valid.
// When rsp stalls, the unit holds the next released entry internally and waits;
// no entry is lost or released twice.
module sequence_reorder_buffer_unit (
    input  logic         clk,
    input  logic         rst_n,
    sqrob_in_if.sink     req,
    sqrob_out_if.source  rsp,
    sqrob_cfg_if.sink    cfg
);
    import sqrob_pkg::*;

    localparam logic [1:0] S_IDLE     = 2'd0;
    localparam logic [1:0] S_CLASSIFY = 2'd1;
    localparam logic [1:0] S_CHECK    = 2'd2;
    localparam logic [1:0] S_LOAD     = 2'd3;

    logic [1:0]        state_reg, state_next;
    id_t               next_exp_reg, next_exp_next;
    logic [CNT_W-1:0]  count_reg, count_next;
    id_t               in_id_reg, in_id_next;
    logic              in_ok_reg, in_ok_next;
    logic [DESC_W-1:0] in_desc_reg, in_desc_next;
    logic              hold_valid_reg, hold_valid_next;
    id_t               hold_id_reg, hold_id_next;
    entry_t            hold_entry_reg, hold_entry_next;
    logic              out_valid_reg, out_valid_next;
    logic [1:0]        out_status_reg, out_status_next;
    id_t               out_id_reg, out_id_next;
    entry_t            out_entry_reg, out_entry_next;
    logic              out_last_reg, out_last_next;

    logic       alu_op;
    id_t        alu_a;
    alu_res_t   alu_res;
    store_cmd_t store_cmd;
    logic       probe_valid;
    entry_t     rd_data;
    logic       out_free;
    logic       more;
    logic       push;
    logic       push_last;
    logic [1:0] push_status;
    id_t        push_id;
    entry_t     push_entry;
    logic       cfg_we;

    sqrob_alu u_alu (
        .op  (alu_op),
        .a   (alu_a),
        .b   (next_exp_reg),
        .res (alu_res)
    );

    sqrob_slot_store u_store (
        .clk         (clk),
        .rst_n       (rst_n),
        .cmd         (store_cmd),
        .probe_slot  (slot_of(next_exp_reg)),
        .probe_valid (probe_valid),
        .rd_data     (rd_data)
    );

    assign req.ready = (state_reg == S_IDLE);
    assign cfg.ready = (state_reg == S_IDLE);
    assign cfg_we    = cfg.valid && cfg.ready;

    assign alu_op   = (state_reg == S_LOAD) ? ALU_INC : ALU_SUB;
    assign alu_a    = (state_reg == S_LOAD) ? next_exp_reg : in_id_reg;
    assign out_free = !out_valid_reg || rsp.ready;
    assign more     = probe_valid && (count_reg < CNT_W'(MAX_RESULTS));

    always_comb
    begin
        state_next      = state_reg;
        next_exp_next   = next_exp_reg;
        count_next      = count_reg;
        in_id_next      = in_id_reg;
        in_ok_next      = in_ok_reg;
        in_desc_next    = in_desc_reg;
        hold_valid_next = hold_valid_reg;
        hold_id_next    = hold_id_reg;
        hold_entry_next = hold_entry_reg;
        store_cmd       = '0;
        push            = 1'b0;
        push_last       = 1'b0;
        push_status     = STATUS_RELEASED;
        push_id         = hold_id_reg;
        push_entry      = hold_entry_reg;

        unique case (state_reg)
            S_IDLE:
            begin
                if (cfg_we)
                begin
                    next_exp_next     = cfg.first_expected_id;
                    store_cmd.clr_all = 1'b1;
                end
                if (req.valid)
                begin
                    in_id_next   = req.seq_id;
                    in_ok_next   = req.ok_flag;
                    in_desc_next = req.descriptor;
                    count_next   = '0;
                    state_next   = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (alu_res.stale || alu_res.beyond)
                begin
                    // echo the rejected transaction once rsp has room
                    if (out_free)
                    begin
                        push            = 1'b1;
                        push_last       = 1'b1;
                        push_status     = alu_res.stale ? STATUS_STALE : STATUS_BEYOND;
                        push_id         = in_id_reg;
                        push_entry.ok   = in_ok_reg;
                        push_entry.desc = in_desc_reg;
                        state_next      = S_IDLE;
                    end
                end
                else
                begin
                    store_cmd.wr_en        = 1'b1;
                    store_cmd.wr_slot      = slot_of(in_id_reg);
                    store_cmd.wr_data.ok   = in_ok_reg;
                    store_cmd.wr_data.desc = in_desc_reg;
                    state_next             = S_CHECK;
                end
            end
            S_CHECK:
            begin
                if (hold_valid_reg)
                begin
                    // last is known only once the following slot is probed
                    if (out_free)
                    begin
                        push            = 1'b1;
                        push_last       = !more;
                        hold_valid_next = 1'b0;
                        if (more)
                        begin
                            store_cmd.rd_en   = 1'b1;
                            store_cmd.rd_slot = slot_of(next_exp_reg);
                            state_next        = S_LOAD;
                        end
                        else
                        begin
                            state_next = S_IDLE;
                        end
                    end
                end
                else if (more)
                begin
                    store_cmd.rd_en   = 1'b1;
                    store_cmd.rd_slot = slot_of(next_exp_reg);
                    state_next        = S_LOAD;
                end
                else
                begin
                    state_next = S_IDLE;
                end
            end
            S_LOAD:
            begin
                hold_valid_next = 1'b1;
                hold_id_next    = next_exp_reg;
                hold_entry_next = rd_data;
                next_exp_next   = alu_res.result;
                count_next      = count_reg + CNT_W'(1);
                state_next      = S_CHECK;
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_comb
    begin
        out_valid_next  = out_valid_reg;
        out_status_next = out_status_reg;
        out_id_next     = out_id_reg;
        out_entry_next  = out_entry_reg;
        out_last_next   = out_last_reg;
        if (push)
        begin
            out_valid_next  = 1'b1;
            out_status_next = push_status;
            out_id_next     = push_id;
            out_entry_next  = push_entry;
            out_last_next   = push_last;
        end
        else if (rsp.ready)
        begin
            out_valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg      <= S_IDLE;
            next_exp_reg   <= ID_W'(1);
            count_reg      <= '0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            state_reg      <= state_next;
            next_exp_reg   <= next_exp_next;
            count_reg      <= count_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        in_id_reg      <= in_id_next;
        in_ok_reg      <= in_ok_next;
        in_desc_reg    <= in_desc_next;
        hold_id_reg    <= hold_id_next;
        hold_entry_reg <= hold_entry_next;
        out_status_reg <= out_status_next;
        out_id_reg     <= out_id_next;
        out_entry_reg  <= out_entry_next;
        out_last_reg   <= out_last_next;
    end

    assign rsp.valid          = out_valid_reg;
    assign rsp.status         = out_status_reg;
    assign rsp.out_seq_id     = out_id_reg;
    assign rsp.out_ok         = out_entry_reg.ok;
    assign rsp.out_descriptor = out_entry_reg.desc;
    assign rsp.last           = out_last_reg;

    a_count_bound: assert property (@(posedge clk) disable iff (!rst_n)
        count_reg <= CNT_W'(MAX_RESULTS))
        else $error("release count exceeds run limit");

    a_hold_in_check: assert property (@(posedge clk) disable iff (!rst_n)
        hold_valid_reg |-> state_reg == S_CHECK)
        else $error("held entry outside the probe state");

    a_more_reads: assert property (@(posedge clk) disable iff (!rst_n)
        push && !push_last |=> state_reg == S_LOAD)
        else $error("non-final release not followed by a slot read");

    a_load_fills_hold: assert property (@(posedge clk) disable iff (!rst_n)
        state_reg == S_LOAD |=> state_reg == S_CHECK && hold_valid_reg)
        else $error("slot read did not land in the hold register");

endmodule
